// ===== rtl/function_call_time_profiler_core_macros.svh =====
// assertion macros for the function call time profiler
// used by the top level; no other dependencies
`ifndef FUNCTION_CALL_TIME_PROFILER_CORE_MACROS_SVH
`define FUNCTION_CALL_TIME_PROFILER_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FCP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FCP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FCP_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg)
`define FCP_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/fcp_pkg.sv =====
// shared types and codes of the function call time profiler
// no dependencies
package fcp_pkg;

  // event kinds
  localparam logic [1:0] OP_ENTER = 2'd0;
  localparam logic [1:0] OP_EXIT  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_ENABLED   = 2'd0;
  localparam logic [1:0] CFG_FILTER_ON = 2'd1;
  localparam logic [1:0] CFG_FILTER_FN = 2'd2;
  localparam logic [1:0] CFG_ITER_LIM  = 2'd3;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 280;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENTER,
    ST_X_ROW,
    ST_X_POOL,
    ST_X_PRD,
    ST_X_PAR,
    ST_NEST,
    ST_READ,
    ST_RESP
  } fcp_state_e;

  typedef struct packed {
    logic        acc;
    logic        fin;
    logic        ovf;
    logic [15:0] depth;
    logic [31:0] calls;
    logic [63:0] total;
    logic [63:0] callee;
    logic [31:0] own;
    logic [63:0] run;
  } fcp_result_t;

endpackage

// ===== rtl/fcp_ram.sv =====
// simple dual port ram, one write and one registered read port
// no dependencies
module fcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/function_call_time_profiler_core.sv =====
// function call time profiler top level: sequencer, counters and stores
// depends on fcp_pkg, fcp_ram and the assertion macro header
//
// One event is taken at a time. Enters and exits pass read-modify-write
// steps through the per-function counter memory, an exit more of them when
// the caller is charged callee time. The result sits in an output register,
// so the next event is taken while it waits. Function rows and pending heads
// carry valid bits that reset and a new session clear at once; no clearing
// pass is needed.
`include "function_call_time_profiler_core_macros.svh"
module function_call_time_profiler_core #(
  parameter int unsigned FUNCTIONS   = 256,
  parameter int unsigned POOL_DEPTH  = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [1:0]                      cfg_idx_i,
  input  logic [15:0]                     cfg_wdata_i,
  // event input
  input  logic                            s_tvalid_i,
  output logic                            s_tready_o,
  // tdata: func_id[7:0], timestamp[39:8]
  input  logic [fcp_pkg::IN_DATA_W-1:0]   s_tdata_i,
  // tuser: op[1:0]
  input  logic [1:0]                      s_tuser_i,
  // result output
  output logic                            m_tvalid_o,
  input  logic                            m_tready_i,
  // tdata: accepted, finished, overflow, depth[15:0], calls[31:0],
  //        incl_time[63:0], callee_time[63:0], self_time[31:0], run_time[63:0]
  output logic [fcp_pkg::OUT_DATA_W-1:0]  m_tdata_o
);
  import fcp_pkg::*;

  localparam int unsigned IDW = $clog2(FUNCTIONS);
  localparam int unsigned SLW = $clog2(POOL_DEPTH);
  localparam int unsigned STW = $clog2(STACK_DEPTH);
  localparam int unsigned PCW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned RAW = 1 + 32 + 64 + 64 + SLW;

  typedef struct packed {
    logic           seen;
    logic [31:0]    calls;
    logic [63:0]    total;
    logic [63:0]    callee;
    logic [SLW-1:0] head;
  } row_t;

  // folds raw function numbers onto the table size
  typedef logic [IDW-1:0] id_lut_t [256];
  function automatic id_lut_t build_lut();
    id_lut_t t;
    for (int i = 0; i < 256; i++) begin
      t[i] = IDW'(i % FUNCTIONS);
    end
    return t;
  endfunction
  localparam id_lut_t IdLut = build_lut();

  fcp_state_e state_q, state_d;

  // configuration
  logic        en_q, en_d, filt_on_q, filt_on_d;
  logic [7:0]  filt_fn_q, filt_fn_d;
  logic [15:0] limit_q, limit_d;

  // control state
  logic [FUNCTIONS-1:0]  rowv_q, rowv_d, hv_q, hv_d;
  logic [POOL_DEPTH-1:0] nv_q, nv_d;
  logic [PCW-1:0]        fresh_q, fresh_d, free_top_q, free_top_d;
  logic [SCW-1:0]        act_q, act_d;
  logic [15:0]           nest_q, nest_d, iter_done_q, iter_done_d;
  logic [31:0]           iter_start_q, iter_start_d;
  logic [63:0]           run_q, run_d;
  logic                  stopped_q, stopped_d, out_valid_q, out_valid_d;

  // event context
  logic [1:0]     op_q, op_d;
  logic [7:0]     raw_q, raw_d;
  logic [IDW-1:0] id_q, id_d, parent_q, parent_d;
  logic [31:0]    ts_q, ts_d, spent_q, spent_d;
  logic           acc_q, acc_d, fin_q, fin_d, ovf_q, ovf_d;
  logic           has_pend_q, has_pend_d, top_match_q, top_match_d;
  row_t           row_q, row_d;
  fcp_result_t    out_q, out_d;

  // memory ports
  logic           fn_we;
  logic [IDW-1:0] fn_waddr, fn_raddr, fn_raddr_q;
  row_t           fn_wdata, fn_rdata, row_rd;
  logic           stk_we;
  logic [STW-1:0] stk_waddr, stk_raddr;
  logic [IDW-1:0] stk_wdata, stk_rdata;
  logic           ps_we;
  logic [SLW-1:0] ps_waddr, ps_raddr;
  logic [31:0]    ps_rdata;
  logic [SLW-1:0] pn_wdata, pn_rdata;
  logic           fl_we;
  logic [SLW-1:0] fl_waddr, fl_raddr, fl_wdata, fl_rdata;

  logic           in_xfer, session_clr, filtered, full;
  logic [SLW-1:0] slot;
  logic [SCW-1:0] act_m1, act_m2;
  logic [PCW-1:0] free_m1;
  logic [IDW-1:0] in_id;
  logic [31:0]    spent;
  logic [15:0]    done_new;

  assign in_xfer     = s_tvalid_i && s_tready_o;
  assign s_tready_o  = (state_q == ST_IDLE);
  assign in_id       = IdLut[s_tdata_i[7:0]];
  assign act_m1      = act_q - SCW'(1);
  assign act_m2      = act_q - SCW'(2);
  assign free_m1     = free_top_q - PCW'(1);
  assign row_rd      = rowv_q[fn_raddr_q] ? fn_rdata : '0;
  assign session_clr = cfg_we_i && (cfg_idx_i == CFG_ENABLED) && cfg_wdata_i[0] && !en_q;
  assign filtered    = (nest_q == 16'd0) && filt_on_q && (raw_q != filt_fn_q);
  assign full        = ((fresh_q == PCW'(POOL_DEPTH)) && (free_top_q == '0)) ||
                       (act_q >= SCW'(STACK_DEPTH));
  assign slot        = (free_top_q != '0) ? fl_rdata : fresh_q[SLW-1:0];
  assign spent       = has_pend_q ? (ts_q - ps_rdata) : 32'd0;
  assign done_new    = (iter_done_q != 16'hFFFF) ? iter_done_q + 16'd1 : iter_done_q;

  // memories
  fcp_ram #(.WIDTH(RAW), .DEPTH(FUNCTIONS)) u_fn_ram (
    .clk_i, .we_i(fn_we), .waddr_i(fn_waddr), .wdata_i(fn_wdata),
    .raddr_i(fn_raddr), .rdata_o(fn_rdata)
  );
  fcp_ram #(.WIDTH(IDW), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );
  fcp_ram #(.WIDTH(32), .DEPTH(POOL_DEPTH)) u_start_ram (
    .clk_i, .we_i(ps_we), .waddr_i(ps_waddr), .wdata_i(ts_q),
    .raddr_i(ps_raddr), .rdata_o(ps_rdata)
  );
  fcp_ram #(.WIDTH(SLW), .DEPTH(POOL_DEPTH)) u_next_ram (
    .clk_i, .we_i(ps_we), .waddr_i(ps_waddr), .wdata_i(pn_wdata),
    .raddr_i(ps_raddr), .rdata_o(pn_rdata)
  );
  fcp_ram #(.WIDTH(SLW), .DEPTH(POOL_DEPTH)) u_free_ram (
    .clk_i, .we_i(fl_we), .waddr_i(fl_waddr), .wdata_i(fl_wdata),
    .raddr_i(fl_raddr), .rdata_o(fl_rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          if (en_q && !stopped_q && (s_tuser_i == OP_ENTER)) begin
            state_d = ST_ENTER;
          end else if (en_q && !stopped_q && (s_tuser_i == OP_EXIT)) begin
            state_d = ST_X_ROW;
          end else begin
            state_d = ST_READ;
          end
        end
      end
      ST_ENTER:  state_d = ST_READ;
      ST_X_ROW:  state_d = ST_X_POOL;
      ST_X_POOL: begin
        if (row_q.seen && top_match_q && (act_q > SCW'(1))) begin
          state_d = ST_X_PRD;
        end else begin
          state_d = ST_NEST;
        end
      end
      ST_X_PRD:  state_d = ST_X_PAR;
      ST_X_PAR:  state_d = ST_NEST;
      ST_NEST:   state_d = ST_READ;
      ST_READ:   state_d = ST_RESP;
      ST_RESP: begin
        if (!out_valid_q || m_tready_i) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    en_d = en_q;  filt_on_d = filt_on_q;  filt_fn_d = filt_fn_q;  limit_d = limit_q;
    rowv_d = rowv_q;  hv_d = hv_q;  nv_d = nv_q;
    fresh_d = fresh_q;  free_top_d = free_top_q;  act_d = act_q;
    nest_d = nest_q;  iter_done_d = iter_done_q;  iter_start_d = iter_start_q;
    run_d = run_q;  stopped_d = stopped_q;
    op_d = op_q;  raw_d = raw_q;  id_d = id_q;  ts_d = ts_q;  parent_d = parent_q;
    acc_d = acc_q;  fin_d = fin_q;  ovf_d = ovf_q;  spent_d = spent_q;
    has_pend_d = has_pend_q;  top_match_d = top_match_q;  row_d = row_q;
    out_d = out_q;
    out_valid_d = out_valid_q && !m_tready_i;
    fn_we = 1'b0;  fn_waddr = id_q;  fn_wdata = row_q;  fn_raddr = id_q;
    stk_we = 1'b0;  stk_waddr = act_q[STW-1:0];  stk_wdata = id_q;
    stk_raddr = act_m1[STW-1:0];
    ps_we = 1'b0;  ps_waddr = slot;  pn_wdata = row_rd.head;  ps_raddr = row_q.head;
    fl_we = 1'b0;  fl_waddr = free_top_q[SLW-1:0];  fl_wdata = row_q.head;
    fl_raddr = free_m1[SLW-1:0];

    case (state_q)
      ST_IDLE: begin
        fn_raddr = in_id;
        if (in_xfer) begin
          op_d  = s_tuser_i;
          raw_d = s_tdata_i[7:0];
          id_d  = in_id;
          ts_d  = s_tdata_i[39:8];
          acc_d = en_q && !stopped_q;
          fin_d = 1'b0;
          ovf_d = 1'b0;
        end
      end
      // push a pending start and the call stack entry
      ST_ENTER: begin
        if (!filtered) begin
          if (full) begin
            ovf_d = 1'b1;
          end else begin
            if (free_top_q != '0) begin
              free_top_d = free_m1;
            end else begin
              fresh_d = fresh_q + PCW'(1);
            end
            ps_we         = 1'b1;
            nv_d[slot]    = hv_q[id_q];
            hv_d[id_q]    = 1'b1;
            fn_we         = 1'b1;
            fn_wdata      = row_rd;
            fn_wdata.seen = 1'b1;
            fn_wdata.head = slot;
            rowv_d[id_q]  = 1'b1;
            stk_we        = 1'b1;
            act_d         = act_q + SCW'(1);
            if (nest_q == 16'd0) begin
              iter_start_d = ts_q;
            end
            if (nest_q != 16'hFFFF) begin
              nest_d = nest_q + 16'd1;
            end
          end
        end
      end
      // row and stack top of the exiting function
      ST_X_ROW: begin
        row_d       = row_rd;
        has_pend_d  = row_rd.seen && hv_q[id_q];
        top_match_d = (act_q != '0) && (stk_rdata == id_q);
        ps_raddr    = row_rd.head;
        stk_raddr   = act_m2[STW-1:0];
      end
      // close the pending start and pop the call stack
      ST_X_POOL: begin
        spent_d = spent;
        if (has_pend_q) begin
          fn_we           = 1'b1;
          fn_wdata        = row_q;
          fn_wdata.calls  = row_q.calls + 32'd1;
          fn_wdata.total  = row_q.total + {32'd0, spent};
          fn_wdata.head   = pn_rdata;
          hv_d[id_q]      = nv_q[row_q.head];
          fl_we           = 1'b1;
          free_top_d      = free_top_q + PCW'(1);
        end
        if (row_q.seen && top_match_q) begin
          act_d    = act_m1;
          parent_d = stk_rdata;
        end
      end
      ST_X_PRD: begin
        fn_raddr = parent_q;
      end
      // charge the caller
      ST_X_PAR: begin
        fn_raddr        = parent_q;
        fn_we           = 1'b1;
        fn_waddr        = parent_q;
        fn_wdata        = row_rd;
        fn_wdata.callee = row_rd.callee + {32'd0, spent_q};
        rowv_d[parent_q] = 1'b1;
      end
      // nesting, iteration bookkeeping and stop
      ST_NEST: begin
        if (nest_q != 16'd0) begin
          nest_d = nest_q - 16'd1;
          if (nest_q == 16'd1) begin
            run_d       = run_q + {32'd0, ts_q - iter_start_q};
            iter_done_d = done_new;
            if ((limit_q != 16'd0) && (done_new >= limit_q)) begin
              stopped_d  = 1'b1;
              fin_d      = 1'b1;
              hv_d       = '0;
              fresh_d    = '0;
              free_top_d = '0;
              act_d      = '0;
              nest_d     = 16'd0;
            end
          end
        end
      end
      ST_READ: begin
        fn_raddr = id_q;
      end
      // format the result
      ST_RESP: begin
        fn_raddr = id_q;
        if (!out_valid_q || m_tready_i) begin
          out_valid_d  = 1'b1;
          out_d.acc    = acc_q;
          out_d.fin    = fin_q;
          out_d.ovf    = ovf_q;
          out_d.depth  = nest_q;
          out_d.calls  = row_rd.calls;
          out_d.total  = row_rd.total;
          out_d.callee = row_rd.callee;
          out_d.own    = row_rd.total[31:0] - row_rd.callee[31:0];
          out_d.run    = run_q;
        end
      end
      default: ;
    endcase

    // configuration writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLED:   en_d      = cfg_wdata_i[0];
        CFG_FILTER_ON: filt_on_d = cfg_wdata_i[0];
        CFG_FILTER_FN: filt_fn_d = cfg_wdata_i[7:0];
        CFG_ITER_LIM:  limit_d   = cfg_wdata_i;
        default: ;
      endcase
    end
    // new session
    if (session_clr) begin
      rowv_d       = '0;
      hv_d         = '0;
      fresh_d      = '0;
      free_top_d   = '0;
      act_d        = '0;
      nest_d       = 16'd0;
      iter_start_d = 32'd0;
      run_d        = 64'd0;
      iter_done_d  = 16'd0;
      stopped_d    = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      en_q         <= 1'b0;
      filt_on_q    <= 1'b0;
      filt_fn_q    <= 8'd0;
      limit_q      <= 16'd0;
      rowv_q       <= '0;
      hv_q         <= '0;
      fresh_q      <= '0;
      free_top_q   <= '0;
      act_q        <= '0;
      nest_q       <= 16'd0;
      iter_done_q  <= 16'd0;
      iter_start_q <= 32'd0;
      run_q        <= 64'd0;
      stopped_q    <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      en_q         <= en_d;
      filt_on_q    <= filt_on_d;
      filt_fn_q    <= filt_fn_d;
      limit_q      <= limit_d;
      rowv_q       <= rowv_d;
      hv_q         <= hv_d;
      fresh_q      <= fresh_d;
      free_top_q   <= free_top_d;
      act_q        <= act_d;
      nest_q       <= nest_d;
      iter_done_q  <= iter_done_d;
      iter_start_q <= iter_start_d;
      run_q        <= run_d;
      stopped_q    <= stopped_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nv_q        <= nv_d;
    op_q        <= op_d;
    raw_q       <= raw_d;
    id_q        <= id_d;
    ts_q        <= ts_d;
    parent_q    <= parent_d;
    acc_q       <= acc_d;
    fin_q       <= fin_d;
    ovf_q       <= ovf_d;
    spent_q     <= spent_d;
    has_pend_q  <= has_pend_d;
    top_match_q <= top_match_d;
    row_q       <= row_d;
    out_q       <= out_d;
    fn_raddr_q  <= fn_raddr;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {(OUT_DATA_W - $bits(fcp_result_t))'(0),
                       out_q.run, out_q.own, out_q.callee, out_q.total,
                       out_q.calls, out_q.depth, out_q.ovf, out_q.fin, out_q.acc};

  // op_q is kept for debug visibility of the event in flight
  logic op_is_exit;
  assign op_is_exit = (op_q == OP_EXIT);

  `FCP_ASSERT_IMPL(a_free_le_fresh, clk_i, rst_ni, 1'b1, free_top_q <= fresh_q, "free list larger than allocated slots")
  `FCP_ASSERT_IMPL(a_stack_bound, clk_i, rst_ni, 1'b1, act_q <= SCW'(STACK_DEPTH), "call stack count out of range")
  `FCP_ASSERT_IMPL(a_fin_acc, clk_i, rst_ni, out_valid_q && out_q.fin, out_q.acc, "finished without accepted")
  `FCP_ASSERT_IMPL(a_stopped_empty, clk_i, rst_ni, stopped_q, (act_q == '0) && (fresh_q == '0), "stores not empty while stopped")
  `FCP_ASSERT_NEXT(a_session_clear, clk_i, rst_ni, session_clr, (run_q == 64'd0) && !stopped_q, "new session did not clear")
  `FCP_ASSERT_IMPL(a_pool_exit, clk_i, rst_ni, state_q == ST_X_POOL, op_is_exit, "exit step without exit event")

endmodule

// ===== test/tb.sv =====
// testbench for function_call_time_profiler_core: directed and random event streams
// checked against a predictor of the per-function counters; depends on fcp_pkg
`timescale 1ns / 100ps
module tb;
  import fcp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_WAIT   = 12;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = CFG_ENABLED;
  logic [15:0] cfg_wdata_i = '0;
  logic s_tvalid_i = 1'b0;
  logic s_tready_o;
  logic [IN_DATA_W-1:0] s_tdata_i = '0;
  logic [1:0] s_tuser_i = OP_READ;
  logic m_tvalid_o;
  logic m_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata_o;

  function_call_time_profiler_core u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .s_tvalid_i, .s_tready_o, .s_tdata_i, .s_tuser_i,
    .m_tvalid_o, .m_tready_i, .m_tdata_o
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predicted profiler state
  bit          fn_seen[256];
  logic [63:0] fn_total[256];
  logic [63:0] fn_callee[256];
  logic [31:0] fn_calls[256];
  bit          head_ok[256];
  logic [4:0]  head_slot[256];
  logic [31:0] slot_ts[32];
  bit          slot_next_ok[32];
  logic [4:0]  slot_next[32];
  bit          slot_idle[32];
  logic [7:0]  frame_ids[32];
  int          stack_cnt;
  logic [15:0] nest_lvl;
  logic [31:0] iter_ts;
  logic [63:0] run_sum;
  logic [15:0] iter_cnt;
  bit          halted;
  bit          r_enabled, r_filt_on;
  logic [7:0]  r_filt_fn;
  logic [15:0] r_limit;

  logic [OUT_DATA_W-1:0] expected_results[$];
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int send_idle = 0;
  int recv_idle = 0;
  logic [31:0] cur_ts = 32'd0;

  function automatic void empty_stores();
    for (int i = 0; i < 256; i++) begin
      head_ok[i] = 1'b0;
      head_slot[i] = '0;
    end
    for (int i = 0; i < 32; i++) begin
      slot_idle[i] = 1'b1;
      slot_next_ok[i] = 1'b0;
    end
    stack_cnt = 0;
    nest_lvl = '0;
  endfunction

  function automatic void clear_session();
    for (int i = 0; i < 256; i++) begin
      fn_seen[i] = 1'b0;
      fn_total[i] = '0;
      fn_callee[i] = '0;
      fn_calls[i] = '0;
    end
    empty_stores();
    iter_ts = '0;
    run_sum = '0;
    iter_cnt = '0;
    halted = 1'b0;
  endfunction

  // update the predictor for one event and return the packed result
  function automatic logic [OUT_DATA_W-1:0] profile_event(logic [1:0] op, logic [7:0] id,
                                                          logic [31:0] ts);
    logic acc, fin, ovf;
    logic [31:0] spent;
    logic [31:0] span;
    int slot;
    acc = r_enabled && !halted;
    fin = 1'b0;
    ovf = 1'b0;
    if (acc && op == OP_ENTER) begin
      if (!(nest_lvl == 0 && r_filt_on && id != r_filt_fn)) begin
        slot = -1;
        for (int i = 31; i >= 0; i--) if (slot_idle[i]) slot = i;
        if (slot < 0 || stack_cnt >= 32) begin
          ovf = 1'b1;
        end else begin
          fn_seen[id] = 1'b1;
          slot_idle[slot] = 1'b0;
          slot_ts[slot] = ts;
          slot_next_ok[slot] = head_ok[id];
          slot_next[slot] = head_slot[id];
          head_ok[id] = 1'b1;
          head_slot[id] = slot[4:0];
          frame_ids[stack_cnt] = id;
          stack_cnt++;
          if (nest_lvl == 0) iter_ts = ts;
          if (nest_lvl != 16'hffff) nest_lvl++;
        end
      end
    end else if (acc && op == OP_EXIT) begin
      if (fn_seen[id]) begin
        spent = '0;
        if (head_ok[id]) begin
          slot = head_slot[id];
          spent = ts - slot_ts[slot];
          fn_total[id] += spent;
          fn_calls[id]++;
          slot_idle[slot] = 1'b1;
          head_ok[id] = slot_next_ok[slot];
          head_slot[id] = slot_next[slot];
        end
        if (stack_cnt > 0 && frame_ids[stack_cnt-1] == id) begin
          stack_cnt--;
          if (stack_cnt > 0) fn_callee[frame_ids[stack_cnt-1]] += spent;
        end
      end
      if (nest_lvl > 0) begin
        nest_lvl--;
        if (nest_lvl == 0) begin
          // iteration length wraps at 32 bits
          span = ts - iter_ts;
          run_sum += {32'd0, span};
          if (iter_cnt != 16'hffff) iter_cnt++;
          if (r_limit != 0 && iter_cnt >= r_limit) begin
            halted = 1'b1;
            fin = 1'b1;
            empty_stores();
          end
        end
      end
    end
    return {5'd0, run_sum, 32'(fn_total[id] - fn_callee[id]), fn_callee[id], fn_total[id],
            fn_calls[id], nest_lvl, ovf, fin, acc};
  endfunction

  // result field layout, lowest bit up
  localparam int FLD_OFF[9] = '{0, 1, 2, 3, 19, 51, 115, 179, 211};
  localparam int FLD_W[9]   = '{1, 1, 1, 16, 32, 64, 64, 32, 64};
  localparam string FLD_NAME[9] = '{"accepted", "finished", "overflow", "depth", "calls",
                                    "incl_time", "callee_time", "self_time", "run_time"};

  // check each result transfer against the oldest prediction
  always @(posedge clk_i) begin
    logic [OUT_DATA_W-1:0] want;
    logic [63:0] mask, w, g;
    if (m_tvalid_o && m_tready_i) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, m_tdata_o);
        fail_cnt++;
      end else begin
        want = expected_results.pop_front();
        for (int k = 0; k < 9; k++) begin
          mask = (FLD_W[k] == 64) ? '1 : ((64'd1 << FLD_W[k]) - 1);
          w = 64'(want >> FLD_OFF[k]) & mask;
          g = 64'(m_tdata_o >> FLD_OFF[k]) & mask;
          if (w !== g) begin
            $display("%0t: %s expected %h actual %h", $time, FLD_NAME[k], w, g);
            fail_cnt++;
          end
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk_i) m_tready_i <= ($urandom_range(99) >= recv_idle);

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_event(logic [1:0] op, logic [7:0] id, logic [31:0] ts);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i <= op;
    s_tdata_i <= {ts, id};
    do @(posedge clk_i); while (!s_tready_o);
    expected_results.push_back(profile_event(op, id, ts));
  endtask

  // register write once the block has drained
  task automatic cfg_write(logic [1:0] idx, logic [15:0] val);
    s_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (IDLE_WAIT) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENABLED: begin
        if (val[0] && !r_enabled) clear_session();
        r_enabled = val[0];
      end
      CFG_FILTER_ON: r_filt_on = val[0];
      CFG_FILTER_FN: r_filt_fn = val[7:0];
      default: r_limit = val;
    endcase
  endtask

  task automatic new_session();
    cfg_write(CFG_ENABLED, 16'd0);
    cfg_write(CFG_ENABLED, 16'd1);
  endtask

  function automatic logic [31:0] next_ts();
    if ($urandom_range(49) == 0) cur_ts = $urandom;
    else cur_ts += $urandom_range(1, 300);
    return cur_ts;
  endfunction

  function automatic logic [7:0] pick_fn();
    return ($urandom_range(9) < 7) ? 8'($urandom_range(7)) : 8'($urandom_range(255));
  endfunction

  // mostly well-formed nesting, some noise events
  task automatic call_sequence(int n, int max_depth);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (stack_cnt == 0 && r < 85)
        send_event(OP_ENTER, (r_filt_on && r < 75) ? r_filt_fn : pick_fn(), next_ts());
      else if (r < 45 && stack_cnt < max_depth)
        send_event(OP_ENTER, pick_fn(), next_ts());
      else if (r < 85 && stack_cnt > 0)
        send_event(OP_EXIT, frame_ids[stack_cnt-1], next_ts());
      else
        send_event(2'($urandom_range(3)), 8'($urandom_range(255)), $urandom);
    end
  endtask

  task automatic test_directed();
    send_event(OP_ENTER, 8'd3, 32'd10);
    send_event(OP_EXIT, 8'd3, 32'd20);
    cfg_write(CFG_ENABLED, 16'hffff);
    send_event(OP_EXIT, 8'd9, 32'd5);
    send_event(OP_ENTER, 8'd0, 32'hffff_fff0);
    send_event(OP_ENTER, 8'd255, 32'hffff_fffe);
    send_event(OP_ENTER, 8'd255, 32'h0000_0004);
    send_event(OP_EXIT, 8'd255, 32'h0000_0010);
    send_event(OP_EXIT, 8'd0, 32'h0000_0020);
    send_event(OP_EXIT, 8'd255, 32'h0000_0030);
    send_event(OP_READ, 8'd255, 32'h0);
    send_event(2'd3, 8'd0, 32'hffff_ffff);
    send_event(OP_EXIT, 8'd0, 32'h0000_0040);
    send_event(OP_EXIT, 8'd0, 32'h0000_0050);
    send_event(OP_READ, 8'd0, 32'h0);
  endtask

  task automatic test_filter();
    new_session();
    cfg_write(CFG_FILTER_ON, 16'd1);
    cfg_write(CFG_FILTER_FN, 16'd255);
    send_event(OP_ENTER, 8'd1, 32'd100);
    send_event(OP_ENTER, 8'd255, 32'd110);
    send_event(OP_ENTER, 8'd1, 32'd120);
    send_event(OP_EXIT, 8'd1, 32'd150);
    send_event(OP_EXIT, 8'd255, 32'd190);
    call_sequence(60, 6);
    cfg_write(CFG_FILTER_FN, 16'd0);
    call_sequence(60, 6);
    cfg_write(CFG_FILTER_FN, 16'($urandom_range(255)));
    call_sequence(40, 6);
    cfg_write(CFG_FILTER_ON, 16'd0);
  endtask

  task automatic test_limit();
    new_session();
    cfg_write(CFG_ITER_LIM, 16'd1);
    send_event(OP_ENTER, 8'd5, 32'd1);
    send_event(OP_ENTER, 8'd6, 32'd3);
    send_event(OP_EXIT, 8'd6, 32'd7);
    send_event(OP_EXIT, 8'd5, 32'd9);
    send_event(OP_ENTER, 8'd5, 32'd11);
    send_event(OP_READ, 8'd5, 32'd0);
    cfg_write(CFG_ITER_LIM, 16'd3);
    new_session();
    call_sequence(80, 5);
    cfg_write(CFG_ITER_LIM, 16'hffff);
    new_session();
    call_sequence(60, 5);
    cfg_write(CFG_ITER_LIM, 16'($urandom_range(2, 9)));
    new_session();
    call_sequence(60, 4);
    cfg_write(CFG_ITER_LIM, 16'd0);
    new_session();
  endtask

  task automatic test_overflow();
    for (int i = 0; i < 36; i++) send_event(OP_ENTER, 8'(i % 5), next_ts());
    for (int i = 0; i < 34; i++)
      send_event(OP_EXIT, (stack_cnt > 0) ? frame_ids[stack_cnt-1] : 8'd0, next_ts());
  endtask

  task automatic test_random(int s_idle, int r_idle, int n);
    send_idle = s_idle;
    recv_idle = r_idle;
    new_session();
    call_sequence(n / 2, 8);
    call_sequence(n / 4, 36);
    new_session();
    call_sequence(n / 4, 12);
  endtask

  initial begin
    r_enabled = 1'b0;
    r_filt_on = 1'b0;
    r_filt_fn = '0;
    r_limit = '0;
    clear_session();
    send_idle = 6;
    recv_idle = 59;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_overflow();
    test_filter();
    test_limit();
    test_random(6, 59, 240);
    test_random(59, 6, 240);
    test_random(0, 0, 240);
    s_tvalid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
